>>> rtl/hbf_pkg.sv
package hbf_pkg;

	localparam int AXES = 3;
	localparam int POS_W = 24;
	localparam int K_W = 16;
	localparam int REST_W = 20;
	localparam int FORCE_W = 27;
	localparam int ENERGY_W = 41;
	localparam int DIFF_W = 26;
	localparam int DMAG_W = 25;
	localparam int RAD_W = 50;
	localparam int ROOT_W = 25;
	localparam int SMAG_W = 26;
	localparam int STR_W = 27;
	localparam int IN_DATA_W = 184;
	localparam int OUT_DATA_W = 128;
	localparam int FORCE_CAP = 1000;
	localparam logic [POS_W-1:0] BOX_RESET = 24'd2228224;
	localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

	typedef logic [AXES-1:0][POS_W-1:0] pos_vec_t;

	typedef struct packed {
		logic [AXES-1:0][DMAG_W-1:0] dmag;
		logic [AXES-1:0]             dneg;
		logic [K_W-1:0]              k;
		logic [REST_W-1:0]           rest;
	} geo_tag_t;

	typedef struct packed {
		logic [ENERGY_W-1:0] energy;
		logic                fneg;
		logic [AXES-1:0]     dneg;
	} div_tag_t;

endpackage

>>> rtl/harmonic_bond_force.sv
// A request passes through the geometry stages, the per-bit square root pipeline, the stretch and
// product stages, the per-bit divider pipeline and the output register.
// Throughput: one bond per cycle; the whole pipeline holds while the output is stalled.
// Reset: arst_n clears all valid bits and loads box_length with 34.0 (Q8.16);
// data registers are not reset.
module harmonic_bond_force #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, spring_constant, rest_length
	input  logic [hbf_pkg::IN_DATA_W-1:0]         s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// force_x, force_y, force_z, bond_energy
	output logic [hbf_pkg::OUT_DATA_W-1:0]        m_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [hbf_pkg::POS_W-1:0]             cfg_data
);

	localparam int A = hbf_pkg::AXES;
	localparam int PW = hbf_pkg::POS_W;
	localparam int KW = hbf_pkg::K_W;
	localparam int RSW = hbf_pkg::REST_W;
	localparam int RTW = hbf_pkg::ROOT_W;
	localparam int MW = hbf_pkg::DMAG_W;
	localparam int SMW = hbf_pkg::SMAG_W;
	localparam int STW = hbf_pkg::STR_W;
	localparam int FOW = hbf_pkg::FORCE_W;
	localparam int EW = hbf_pkg::ENERGY_W;
	localparam int FW = FRAC_BITS + 10;
	localparam int NUM_W = FW + MW + 1;
	localparam int PM_W = KW + SMW;
	localparam int D2_W = 2 * SMW;
	localparam int HALF = D2_W / 2;
	localparam int E_W = KW + D2_W + 1;
	localparam int SH = FRAC_BITS + 7;
	localparam int GT_W = $bits(hbf_pkg::geo_tag_t);
	localparam int DT_W = $bits(hbf_pkg::div_tag_t);
	localparam logic [PM_W-1:0] LIM = PM_W'(hbf_pkg::FORCE_CAP) << (FRAC_BITS + 6);
	localparam logic [FW-1:0] CAPQ = FW'(hbf_pkg::FORCE_CAP) << FRAC_BITS;
	localparam logic [E_W-1:0] EROUND = E_W'(1) << (SH - 1);

	logic en;
	logic [PW-1:0] box_q;

	hbf_pkg::pos_vec_t pos_a, pos_b;
	logic geo_vld;
	logic [hbf_pkg::RAD_W-1:0] geo_sq;
	hbf_pkg::geo_tag_t geo_tag, sq_tag;
	logic [GT_W-1:0] sq_tag_raw;
	logic sq_vld;
	logic [RTW-1:0] root;

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= hbf_pkg::BOX_RESET;
		end else if (cfg_valid) begin
			box_q <= cfg_data;
		end
	end

	for (genvar i = 0; i < A; i++) begin : g_unpack
		assign pos_a[i] = s_tdata[i*PW +: PW];
		assign pos_b[i] = s_tdata[(i+A)*PW +: PW];
	end

	hbf_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.pos_a     (pos_a),
		.pos_b     (pos_b),
		.k         (s_tdata[2*A*PW +: KW]),
		.rest      (s_tdata[2*A*PW+KW +: RSW]),
		.box       (box_q),
		.out_valid (geo_vld),
		.sq        (geo_sq),
		.out_tag   (geo_tag)
	);

	hbf_sqrt #(.TAG_W(GT_W)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (geo_vld),
		.rad       (geo_sq),
		.in_tag    (geo_tag),
		.out_valid (sq_vld),
		.root      (root),
		.out_tag   (sq_tag_raw)
	);

	assign sq_tag = hbf_pkg::geo_tag_t'(sq_tag_raw);

	// stretch
	logic [RTW-1:0] bond_len;
	logic signed [STW-1:0] stretch;
	logic vld_s4, vld_s5, vld_s6, vld_s7;
	logic [RTW-1:0] dist_s4, dist_s5, dist_s6, dist_s7;
	logic [SMW-1:0] smag_s4;
	logic spos_s4;
	logic [KW-1:0] k_s4, k_s5;
	logic [A-1:0][MW-1:0] dmag_s4, dmag_s5, dmag_s6;
	logic [A-1:0] dneg_s4, dneg_s5, dneg_s6, dneg_s7;

	assign bond_len = (root == '0) ? RTW'(1) : root;
	assign stretch = $signed({2'b00, bond_len}) - $signed({7'b0, sq_tag.rest});

	// products
	logic [PM_W-1:0] pmag_s5;
	logic [D2_W-1:0] d2_s5;
	logic fneg_s5, fneg_s6, fneg_s7;

	// force magnitude, energy partials
	logic [PM_W-1:0] pclamp;
	logic [PM_W-1:0] pround;
	logic [FW-1:0] fmag_s6;
	logic [PM_W-1:0] elo_s6, ehi_s6;

	// numerators, energy
	logic [NUM_W-1:0] num_s7 [A];
	logic [EW-1:0] energy_s7;
	logic [E_W-1:0] esum, eshift;

	assign pclamp = (pmag_s5 > LIM) ? LIM : pmag_s5;
	assign pround = pclamp + PM_W'(32);
	assign esum = (E_W'(ehi_s6) << HALF) + E_W'(elo_s6) + EROUND;
	assign eshift = esum >> SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s4 <= sq_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s4 <= bond_len;
			smag_s4 <= stretch[STW-1] ? SMW'(-stretch) : SMW'(stretch);
			spos_s4 <= !stretch[STW-1] && (stretch != '0);
			k_s4 <= sq_tag.k;
			dmag_s4 <= sq_tag.dmag;
			dneg_s4 <= sq_tag.dneg;

			pmag_s5 <= k_s4 * smag_s4;
			d2_s5 <= smag_s4 * smag_s4;
			fneg_s5 <= spos_s4 && (k_s4 != '0);
			k_s5 <= k_s4;
			dist_s5 <= dist_s4;
			dmag_s5 <= dmag_s4;
			dneg_s5 <= dneg_s4;

			fmag_s6 <= FW'(pround >> 6);
			elo_s6 <= k_s5 * d2_s5[HALF-1:0];
			ehi_s6 <= k_s5 * d2_s5[D2_W-1:HALF];
			fneg_s6 <= fneg_s5;
			dist_s6 <= dist_s5;
			dmag_s6 <= dmag_s5;
			dneg_s6 <= dneg_s5;

			energy_s7 <= (eshift > E_W'(hbf_pkg::ENERGY_MAX)) ? hbf_pkg::ENERGY_MAX
				: eshift[EW-1:0];
			fneg_s7 <= fneg_s6;
			dist_s7 <= dist_s6;
			dneg_s7 <= dneg_s6;
		end
	end

	for (genvar l = 0; l < A; l++) begin : g_num
		logic [FW+MW-1:0] prd;
		assign prd = fmag_s6 * dmag_s6[l];
		always_ff @(posedge clk) begin
			if (en) begin
				num_s7[l] <= NUM_W'(prd) + NUM_W'(dist_s6 >> 1);
			end
		end
	end

	hbf_pkg::div_tag_t dv_tag_in, dv_tag;
	logic [DT_W-1:0] dv_tag_raw;
	logic dv_vld;
	logic [FW-1:0] quo [A];

	assign dv_tag_in.energy = energy_s7;
	assign dv_tag_in.fneg = fneg_s7;
	assign dv_tag_in.dneg = dneg_s7;

	hbf_div #(.NUM_W(NUM_W), .QUO_W(FW), .TAG_W(DT_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s7),
		.num       (num_s7),
		.den       (dist_s7),
		.in_tag    (dv_tag_in),
		.out_valid (dv_vld),
		.quo       (quo),
		.out_tag   (dv_tag_raw)
	);

	assign dv_tag = hbf_pkg::div_tag_t'(dv_tag_raw);

	// output register
	logic vld_s8;
	logic [FOW-1:0] force_s8 [A];
	logic [EW-1:0] energy_s8;

	for (genvar l = 0; l < A; l++) begin : g_force
		logic [FW-1:0] cm;
		logic [FOW-1:0] cx;
		assign cm = (quo[l] > CAPQ) ? CAPQ : quo[l];
		assign cx = FOW'(cm);
		always_ff @(posedge clk) begin
			if (en) begin
				force_s8[l] <= (dv_tag.fneg != dv_tag.dneg[l]) ? -cx : cx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			energy_s8 <= dv_tag.energy;
		end
	end

	assign m_tvalid = vld_s8;
	assign m_tdata = {6'b0, energy_s8, force_s8[2], force_s8[1], force_s8[0]};

endmodule

>>> rtl/hbf_geom.sv
module hbf_geom (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  hbf_pkg::pos_vec_t                    pos_a,
	input  hbf_pkg::pos_vec_t                    pos_b,
	input  logic [hbf_pkg::K_W-1:0]              k,
	input  logic [hbf_pkg::REST_W-1:0]           rest,
	input  logic [hbf_pkg::POS_W-1:0]            box,
	output logic                                 out_valid,
	output logic [hbf_pkg::RAD_W-1:0]            sq,
	output hbf_pkg::geo_tag_t                    out_tag
);

	localparam int A = hbf_pkg::AXES;
	localparam int DW = hbf_pkg::DIFF_W;
	localparam int MW = hbf_pkg::DMAG_W;
	localparam int RW = hbf_pkg::RAD_W;

	logic signed [DW-1:0] d_s1 [A];
	logic [hbf_pkg::K_W-1:0] k_s1, k_s2;
	logic [hbf_pkg::REST_W-1:0] rest_s1, rest_s2;
	logic [RW-1:0] sq_s2 [A];
	logic [A-1:0][MW-1:0] dmag_s2;
	logic [A-1:0] dneg_s2;
	logic vld_s1, vld_s2, vld_s3;
	logic [RW-1:0] sq_s3;
	hbf_pkg::geo_tag_t tag_s3;

	for (genvar i = 0; i < A; i++) begin : g_axis
		logic signed [DW-1:0] d0, d1, d2, lw;
		logic signed [DW:0] tw0, tw1, lx;
		logic [MW-1:0] mag;

		always_comb begin
			lw = $signed({2'b00, box});
			lx = $signed({3'b000, box});
			d0 = $signed({2'b00, pos_a[i]}) - $signed({2'b00, pos_b[i]});
			tw0 = {d0, 1'b0};
			d1 = (tw0 > lx) ? d0 - lw : d0;
			tw1 = {d1, 1'b0};
			d2 = (tw1 < -lx) ? d1 + lw : d1;
		end

		assign mag = d_s1[i][DW-1] ? MW'(-d_s1[i]) : MW'(d_s1[i]);

		always_ff @(posedge clk) begin
			if (en) begin
				d_s1[i] <= d2;
				dmag_s2[i] <= mag;
				dneg_s2[i] <= d_s1[i][DW-1];
				sq_s2[i] <= mag * mag;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s1 <= k;
			rest_s1 <= rest;
			k_s2 <= k_s1;
			rest_s2 <= rest_s1;
			sq_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			tag_s3.dmag <= dmag_s2;
			tag_s3.dneg <= dneg_s2;
			tag_s3.k <= k_s2;
			tag_s3.rest <= rest_s2;
		end
	end

	assign out_valid = vld_s3;
	assign sq = sq_s3;
	assign out_tag = tag_s3;

endmodule

>>> rtl/hbf_sqrt.sv
module hbf_sqrt #(
	parameter int TAG_W = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [hbf_pkg::RAD_W-1:0]    rad,
	input  logic [TAG_W-1:0]             in_tag,
	output logic                         out_valid,
	output logic [hbf_pkg::ROOT_W-1:0]   root,
	output logic [TAG_W-1:0]             out_tag
);

	localparam int N = hbf_pkg::ROOT_W;
	localparam int W = hbf_pkg::RAD_W + 1;

	logic [W-1:0] rem_s [N];
	logic [W-1:0] res_s [N];
	logic [TAG_W-1:0] tag_s [N];
	logic vld_s [N];

	for (genvar i = 0; i < N; i++) begin : g_step
		logic [W-1:0] rem_i, res_i, bit_i, trial;
		logic [TAG_W-1:0] tag_i;
		logic vld_i;

		if (i == 0) begin : g_first
			assign rem_i = {1'b0, rad};
			assign res_i = '0;
			assign tag_i = in_tag;
			assign vld_i = in_valid;
		end else begin : g_next
			assign rem_i = rem_s[i-1];
			assign res_i = res_s[i-1];
			assign tag_i = tag_s[i-1];
			assign vld_i = vld_s[i-1];
		end

		assign bit_i = W'(1) << (2 * (N - 1 - i));
		assign trial = res_i + bit_i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_i >= trial) begin
					rem_s[i] <= rem_i - trial;
					res_s[i] <= (res_i >> 1) + bit_i;
				end else begin
					rem_s[i] <= rem_i;
					res_s[i] <= res_i >> 1;
				end
				tag_s[i] <= tag_i;
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign root = res_s[N-1][N-1:0];
	assign out_tag = tag_s[N-1];

endmodule

>>> rtl/hbf_div.sv
module hbf_div #(
	parameter int NUM_W = 52,
	parameter int QUO_W = 26,
	parameter int TAG_W = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [NUM_W-1:0]             num [hbf_pkg::AXES],
	input  logic [hbf_pkg::ROOT_W-1:0]   den,
	input  logic [TAG_W-1:0]             in_tag,
	output logic                         out_valid,
	output logic [QUO_W-1:0]             quo [hbf_pkg::AXES],
	output logic [TAG_W-1:0]             out_tag
);

	localparam int A = hbf_pkg::AXES;
	localparam int DW = hbf_pkg::ROOT_W;

	logic [NUM_W-1:0] rem_s [QUO_W][A];
	logic [QUO_W-1:0] quo_s [QUO_W][A];
	logic [DW-1:0] den_s [QUO_W];
	logic [TAG_W-1:0] tag_s [QUO_W];
	logic vld_s [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_step
		logic [DW-1:0] den_i;
		logic [TAG_W-1:0] tag_i;
		logic vld_i;
		logic [NUM_W-1:0] sub_i;

		if (i == 0) begin : g_first
			assign den_i = den;
			assign tag_i = in_tag;
			assign vld_i = in_valid;
		end else begin : g_next
			assign den_i = den_s[i-1];
			assign tag_i = tag_s[i-1];
			assign vld_i = vld_s[i-1];
		end

		assign sub_i = NUM_W'(den_i) << (QUO_W - 1 - i);

		for (genvar l = 0; l < A; l++) begin : g_lane
			logic [NUM_W-1:0] rem_i;
			logic [QUO_W-1:0] q_i;
			logic ge;

			if (i == 0) begin : g_first
				assign rem_i = num[l];
				assign q_i = '0;
			end else begin : g_next
				assign rem_i = rem_s[i-1][l];
				assign q_i = quo_s[i-1][l];
			end

			assign ge = rem_i >= sub_i;

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i][l] <= ge ? rem_i - sub_i : rem_i;
					quo_s[i][l] <= QUO_W'({q_i, ge});
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i] <= den_i;
				tag_s[i] <= tag_i;
			end
		end
	end

	assign out_valid = vld_s[QUO_W-1];
	assign out_tag = tag_s[QUO_W-1];
	for (genvar l = 0; l < A; l++) begin : g_out
		assign quo[l] = quo_s[QUO_W-1][l];
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int FRAC = 16;
	localparam int LATENCY = 59;

	typedef struct packed {
		logic [hbf_pkg::POS_W-1:0] ax, ay, az, bx, by, bz;
		logic [hbf_pkg::K_W-1:0] k;
		logic [hbf_pkg::REST_W-1:0] rest;
	} bond_t;

	typedef struct packed {
		logic [hbf_pkg::ENERGY_W-1:0] energy;
		logic [hbf_pkg::FORCE_W-1:0] fz, fy, fx;
	} force_t;

	typedef struct {
		bond_t b;
		logic chk;
		force_t f;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [hbf_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [hbf_pkg::OUT_DATA_W-1:0] m_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [hbf_pkg::POS_W-1:0] cfg_data = '0;

	logic [hbf_pkg::POS_W-1:0] box = hbf_pkg::BOX_RESET;
	force_t expected_forces[$];
	int errors = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int hold_off = 0;

	harmonic_bond_force dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	function automatic force_t bond_force(bond_t b);
		longint d[3];
		logic [hbf_pkg::POS_W-1:0] pa[3], pb[3];
		longint side, prod, lim, stretch;
		logic [63:0] sq, blen, fmag, pmag, dmag, cmag, smag, d2, hi, lo, en, capq;
		logic fneg, dneg;
		logic [hbf_pkg::FORCE_W-1:0] comp[3];
		force_t f;
		pa = '{b.ax, b.ay, b.az};
		pb = '{b.bx, b.by, b.bz};
		side = longint'(box);
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			d[i] = longint'(pa[i]) - longint'(pb[i]);
			if (2 * d[i] > side) d[i] -= side;
			if (2 * d[i] < -side) d[i] += side;
			sq += d[i] * d[i];
		end
		blen = int_sqrt(sq);
		if (blen < 1) blen = 1;
		stretch = longint'(blen) - longint'(b.rest);
		prod = -(longint'(b.k) * stretch);
		lim = longint'(hbf_pkg::FORCE_CAP) <<< (FRAC + 6);
		if (prod > lim) prod = lim;
		if (prod < -lim) prod = -lim;
		fneg = prod < 0;
		pmag = fneg ? -prod : prod;
		fmag = (pmag + 32) >> 6;
		capq = 64'(hbf_pkg::FORCE_CAP) << FRAC;
		for (int i = 0; i < 3; i++) begin
			dneg = d[i] < 0;
			dmag = dneg ? -d[i] : d[i];
			cmag = (fmag * dmag + (blen >> 1)) / blen;
			if (cmag > capq) cmag = capq;
			comp[i] = (fneg != dneg) ? hbf_pkg::FORCE_W'(64'd0 - cmag)
				: hbf_pkg::FORCE_W'(cmag);
		end
		smag = stretch < 0 ? -stretch : stretch;
		d2 = smag * smag;
		hi = d2 >> 32;
		lo = d2 & 64'hFFFF_FFFF;
		en = ((64'(b.k) * hi) << (32 - 23)) + ((64'(b.k) * lo + (64'd1 << 22)) >> 23);
		if (en > 64'(hbf_pkg::ENERGY_MAX)) en = 64'(hbf_pkg::ENERGY_MAX);
		f.fx = comp[0];
		f.fy = comp[1];
		f.fz = comp[2];
		f.energy = en[hbf_pkg::ENERGY_W-1:0];
		return f;
	endfunction

	function automatic logic [hbf_pkg::IN_DATA_W-1:0] pack_bond(bond_t b);
		return {4'b0, b.rest, b.k, b.bz, b.by, b.bx, b.az, b.ay, b.ax};
	endfunction

	function automatic bond_t random_bond();
		bond_t b;
		logic [hbf_pkg::POS_W-1:0] base;
		b.ax = $urandom; b.ay = $urandom; b.az = $urandom;
		b.bx = $urandom; b.by = $urandom; b.bz = $urandom;
		b.k = $urandom;
		b.rest = $urandom;
		if ($urandom_range(0, 3) != 0) begin
			// realistic bond: atoms close, rest near distance
			base = $urandom;
			b.ax = base; b.bx = base + $urandom_range(0, 262143) - 131072;
			base = $urandom;
			b.ay = base; b.by = base + $urandom_range(0, 262143) - 131072;
			base = $urandom;
			b.az = base; b.bz = base + $urandom_range(0, 262143) - 131072;
			b.rest = $urandom_range(0, 200000);
			b.k = $urandom_range(0, 40000);
		end
		return b;
	endfunction

	task automatic send_bond(bond_t b, int idle_pct);
		@(negedge clk);
		while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tdata <= pack_bond(b);
		s_tvalid <= 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_forces.insert(expected_forces.size(), bond_force(b));
	endtask

	task automatic idle_input();
		@(negedge clk);
		s_tvalid <= 0;
	endtask

	task automatic write_box(logic [hbf_pkg::POS_W-1:0] v);
		while (expected_forces.size() != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
		cfg_data <= v;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		box = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	always @(posedge clk) begin
		force_t got, want;
		if (m_tvalid && m_tready) begin
			got = force_t'(m_tdata[hbf_pkg::FORCE_W*3+hbf_pkg::ENERGY_W-1:0]);
			if (expected_forces.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = expected_forces.pop_front();
				if (got.fx !== want.fx) begin
					$display("%0t: force_x expected %h actual %h", $time, want.fx, got.fx);
					errors++;
				end
				if (got.fy !== want.fy) begin
					$display("%0t: force_y expected %h actual %h", $time, want.fy, got.fy);
					errors++;
				end
				if (got.fz !== want.fz) begin
					$display("%0t: force_z expected %h actual %h", $time, want.fz, got.fz);
					errors++;
				end
				if (got.energy !== want.energy) begin
					$display("%0t: energy expected %h actual %h", $time, want.energy,
						got.energy);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 0;
		end else begin
			m_tready <= !(recv_stall > 0 && $urandom_range(0, 99) < recv_stall);
		end
	end

	initial begin
		#50_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		row_t rows[$];
		row_t r;
		bond_t b;
		force_t f;
		logic [hbf_pkg::POS_W-1:0] boxes[6];
		repeat (10) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// coincident atoms, zero k: all zero
		b = '{default: '0};
		r.b = b; r.chk = 1; r.f = '0; rows.insert(rows.size(), r);
		// coincident, k max, rest 0: distance 1 LSB, zero displacement gives zero force projection
		b.k = '1; r.b = b; r.chk = 0; rows.insert(rows.size(), r);
		b.rest = '1; r.b = b; rows.insert(rows.size(), r);
		b = '{default: '1}; r.b = b; rows.insert(rows.size(), r);
		b = '{default: '0}; b.ax = '1; b.k = '1; r.b = b; rows.insert(rows.size(), r);
		b = '{default: '0}; b.bx = '1; b.by = '1; b.bz = '1; b.k = 16'd64;
		r.b = b; rows.insert(rows.size(), r);
		b = '{default: '0}; b.ax = 24'd1114112; b.k = 16'd64; r.b = b;
		rows.insert(rows.size(), r);
		b.ax = 24'd1114113; r.b = b; rows.insert(rows.size(), r);
		b.ax = 0; b.bx = 24'd1114112; r.b = b; rows.insert(rows.size(), r);
		b.bx = 24'd1114113; r.b = b; rows.insert(rows.size(), r);
		b = '{default: '0}; b.ay = 24'd65536; b.rest = 20'd65536; b.k = '1;
		r.b = b; rows.insert(rows.size(), r);
		b.rest = 0; r.b = b; rows.insert(rows.size(), r);
		b.rest = '1; r.b = b; rows.insert(rows.size(), r);
		b = '{default: '0}; b.az = 24'h555555; b.bz = 24'hAAAAAA; b.k = 16'h5555;
		b.rest = 20'hAAAAA; r.b = b; rows.insert(rows.size(), r);
		foreach (rows[i]) begin
			send_bond(rows[i].b, 0);
			if (rows[i].chk) begin
				f = expected_forces[$];
				if (f !== rows[i].f) begin
					$display("%0t: table row %0d expected %h predicted %h", $time, i,
						rows[i].f, f);
					errors++;
				end
			end
		end
		idle_input();

		boxes = '{24'd0, 24'd65535, 24'd65536, 24'hFFFFFF, 24'd1000000,
			hbf_pkg::BOX_RESET};
		for (int ph = 0; ph < 6; ph++) begin
			write_box(boxes[ph]);
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 88; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 88; end
				3: begin send_idle = 29; recv_stall = 29; end
				4: begin send_idle = 0; recv_stall = 0; hold_off = 400; end
				default: begin send_idle = 29; recv_stall = 29; end
			endcase
			for (int n = 0; n < 122; n++) begin
				send_bond(random_bond(), send_idle);
				if (ph == 3 && n == 60) begin
					idle_input();
					while (expected_forces.size() != 0) @(negedge clk);
				end
			end
			idle_input();
		end

		while (expected_forces.size() != 0) @(negedge clk);
		repeat (LATENCY + 20) @(negedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

>>> files.f
rtl/hbf_pkg.sv
rtl/hbf_geom.sv
rtl/hbf_sqrt.sv
rtl/hbf_div.sv
rtl/harmonic_bond_force.sv
tb/tb_top.sv
